>>> hw/rtl/weighted_random_selector_macros.svh
// Assertion helpers for the weighted random selector.
`ifndef WEIGHTED_RANDOM_SELECTOR_MACROS_SVH
`define WEIGHTED_RANDOM_SELECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WRS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define WRS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/wrs_pkg.sv
`default_nettype none

package wrs_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int WGT_W       = 15;
    localparam int SUM_W       = 19;
    localparam int FINE_W      = 14;
    localparam int CHANCE_W    = 7;
    localparam int LHS_W       = FINE_W + SUM_W;
    localparam int SCALE_W     = 14;
    localparam int PROD_W      = WGT_W + SCALE_W;
    localparam int ACC_W       = LHS_W;
    localparam int ROLL_SCALE  = 10000;
    localparam int ONE_Q8_8    = 256;
    localparam int CHANCE_RST  = 100;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_PICK = 1'b1;

    typedef enum logic [1:0] {
        STAT_ADDED  = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_PICKED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] index;
    } t_scan_res;

endpackage

`default_nettype wire

>>> hw/rtl/wrs_store.sv
`default_nettype none

module wrs_store (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [wrs_pkg::IDX_W-1:0] i_waddr,
    input  wire  [wrs_pkg::WGT_W-1:0] i_wdata,
    input  wire  [wrs_pkg::IDX_W-1:0] i_raddr,
    output logic [wrs_pkg::WGT_W-1:0] o_rdata
);
    import wrs_pkg::*;

    logic [WGT_W-1:0] r_mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/wrs_scan.sv
`default_nettype none

// Cumulative-weight scan: one read per cycle, scale by the roll range,
// accumulate and compare against fine_roll * total.
module wrs_scan (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [wrs_pkg::FINE_W-1:0] i_fine,
    input  wire  [wrs_pkg::SUM_W-1:0]  i_sum,
    input  wire  [wrs_pkg::CNT_W-1:0]  i_count,
    input  wire  [wrs_pkg::WGT_W-1:0]  i_rdata,
    output logic [wrs_pkg::IDX_W-1:0]  o_raddr,
    output wrs_pkg::t_scan_res         o_res
);
    import wrs_pkg::*;

    logic             r_busy;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] r_count;
    logic [LHS_W-1:0] r_lhs;
    logic [ACC_W-1:0] r_acc;
    logic             r_v1;
    logic             r_l1;
    logic [IDX_W-1:0] r_i1;
    logic             r_v2;
    logic             r_l2;
    logic [IDX_W-1:0] r_i2;
    logic [PROD_W-1:0] r_prod;

    logic             issue_v;
    logic [ACC_W-1:0] acc_new;
    logic             hit;
    logic             done;

    assign issue_v = r_busy && (r_issue < r_count);
    assign o_raddr = r_issue[IDX_W-1:0];
    assign acc_new = r_acc + ACC_W'(r_prod);
    assign hit     = r_lhs <= acc_new;
    assign done    = r_v2 && (hit || r_l2);

    assign o_res.done  = done;
    assign o_res.index = r_i2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else if (done) begin
            // drop whatever is still in flight
            r_busy <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            r_v1 <= issue_v;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lhs   <= LHS_W'(i_fine) * LHS_W'(i_sum);
            r_acc   <= '0;
            r_issue <= '0;
            r_count <= i_count;
        end else begin
            if (issue_v) begin
                r_issue <= r_issue + 1'b1;
            end
            if (r_v2) begin
                r_acc <= acc_new;
            end
        end
        r_i1   <= r_issue[IDX_W-1:0];
        r_l1   <= (r_issue + 1'b1) == r_count;
        r_i2   <= r_i1;
        r_l2   <= r_l1;
        r_prod <= PROD_W'(i_rdata) * PROD_W'(ROLL_SCALE);
    end

endmodule

`default_nettype wire

>>> hw/rtl/weighted_random_selector.sv
`default_nettype none

// Weighted random selector: a table of up to 16 Q8.8 weights and their total.
// Input channel (i_in_valid / o_in_ready): opcode 0 adds i_weight (zero or
// negative is stored as 1.0); opcode 1 picks with i_chance_roll and
// i_fine_roll. Output channel (o_out_valid / i_out_ready) carries one item per
// input: status, entry index and the entry total after the item.
// i_cfg_we writes the appear-chance percent at once; set it only while idle.
// An add or a gated pick passes from acceptance through the execute and emit
// states to o_out_valid. A pick that scans also passes through the scan state,
// which lasts longer the higher the index of the picked entry; the scan reads
// one weight per cycle from the table's single read port, then scales and
// accumulates through the read-data and product registers.
// One item at a time: o_in_ready rises again once the result is loaded into
// the output register, so the next item can be accepted while it waits.
// A stalled receiver holds the result; a finished item waits in the block until
// the output register frees up.
// Reset (synchronous, active low) empties the table, clears the total and sets
// the chance to 100 percent; the weight memory itself is not cleared.
module weighted_random_selector (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire                          i_opcode,
    input  wire  signed [15:0]           i_weight,
    input  wire  [wrs_pkg::CHANCE_W-1:0] i_chance_roll,
    input  wire  [wrs_pkg::FINE_W-1:0]   i_fine_roll,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [1:0]                   o_status,
    output logic [3:0]                   o_entry_index,
    output logic [4:0]                   o_entry_total,
    input  wire                          i_cfg_we,
    input  wire  [wrs_pkg::CHANCE_W-1:0] i_cfg_wdata
);
    import wrs_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_opcode;
    logic signed [15:0]  r_weight;
    logic [CHANCE_W-1:0] r_chance_roll;
    logic [FINE_W-1:0]   r_fine_roll;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [CHANCE_W-1:0] r_cfg_chance;
    t_status             r_res_status;
    logic [IDX_W-1:0]    r_res_index;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [IDX_W-1:0]    r_out_index;
    logic [CNT_W-1:0]    r_out_total;

    logic             in_acc;
    logic             full;
    logic             gate_ok;
    logic             out_free;
    logic             add_we;
    logic             scan_start;
    logic             out_load;
    logic [WGT_W-1:0] add_w;
    logic [WGT_W-1:0] rdata;
    logic [IDX_W-1:0] raddr;
    t_scan_res        scan_res;

    function automatic logic i_weight_le_zero(input logic signed [15:0] w);
        return w[15] || (w == '0);
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign full     = r_count >= CNT_W'(MAX_ENTRIES);
    assign gate_ok  = (r_count != '0) && (r_chance_roll < r_cfg_chance);
    assign out_free = !r_out_valid || i_out_ready;
    assign add_w    = (i_weight_le_zero(r_weight)) ? WGT_W'(ONE_Q8_8) : r_weight[WGT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (r_opcode == OP_PICK && gate_ok) n_state = ST_SCAN;
                else                                n_state = ST_EMIT;
            end
            ST_SCAN: begin
                if (scan_res.done) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        add_we     = 1'b0;
        scan_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EXEC: begin
                add_we     = (r_opcode == OP_ADD) && !full;
                scan_start = (r_opcode == OP_PICK) && gate_ok;
            end
            ST_SCAN: ;
            ST_EMIT: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_sum        <= '0;
            r_cfg_chance <= CHANCE_W'(CHANCE_RST);
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg_chance <= i_cfg_wdata;
            end
            if (add_we) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(add_w);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_opcode      <= i_opcode;
            r_weight      <= i_weight;
            r_chance_roll <= i_chance_roll;
            r_fine_roll   <= i_fine_roll;
        end
        if (r_state == ST_EXEC) begin
            if (r_opcode == OP_ADD) begin
                r_res_status <= full ? STAT_FULL : STAT_ADDED;
                r_res_index  <= full ? '0 : r_count[IDX_W-1:0];
            end else begin
                r_res_status <= STAT_NONE;
                r_res_index  <= '0;
            end
        end else if (r_state == ST_SCAN && scan_res.done) begin
            r_res_status <= STAT_PICKED;
            r_res_index  <= scan_res.index;
        end
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_index  <= r_res_index;
            r_out_total  <= r_count;
        end
    end

    wrs_store u_store (
        .i_clk   (i_clk),
        .i_we    (add_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (add_w),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    wrs_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_fine  (r_fine_roll),
        .i_sum   (r_sum),
        .i_count (r_count),
        .i_rdata (rdata),
        .o_raddr (raddr),
        .o_res   (scan_res)
    );

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_index = 4'(r_out_index);
    assign o_entry_total = 5'(r_out_total);

`include "weighted_random_selector_macros.svh"

    `WRS_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(MAX_ENTRIES), "entry count overflow")
    `WRS_ASSERT_NOW(a_empty_sum, r_count == '0, r_sum == '0, "total nonzero with empty table")
    `WRS_ASSERT_NOW(a_scan_state, scan_res.done, r_state == ST_SCAN, "scan done outside scan")
    `WRS_ASSERT_NOW(a_pick_range, r_out_valid && r_out_status == STAT_PICKED, r_out_index < r_out_total, "picked index beyond table")

endmodule

`default_nettype wire

>>> dv/tb_weighted_random_selector.sv
`timescale 1ns / 1ps

module tb_weighted_random_selector;
    import wrs_pkg::*;

    typedef struct packed {
        t_status    status;
        logic [3:0] index;
        logic [4:0] total;
    } t_sel_result;

    typedef struct {
        logic                op;
        logic [15:0]         weight;
        logic [CHANCE_W-1:0] chance_roll;
        logic [FINE_W-1:0]   fine_roll;
        bit                  typed;
        t_sel_result         res;
    } t_step_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_opcode;
    logic [15:0]         i_weight;
    logic [CHANCE_W-1:0] i_chance_roll;
    logic [FINE_W-1:0]   i_fine_roll;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [1:0]          o_status;
    logic [3:0]          o_entry_index;
    logic [4:0]          o_entry_total;
    logic                i_cfg_we;
    logic [CHANCE_W-1:0] i_cfg_wdata;

    weighted_random_selector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_weight      (i_weight),
        .i_chance_roll (i_chance_roll),
        .i_fine_roll   (i_fine_roll),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_entry_index (o_entry_index),
        .o_entry_total (o_entry_total),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Shadow copy of the weight table and the chance register
    logic [WGT_W-1:0]    tbl_weight [MAX_ENTRIES];
    int unsigned         tbl_count = 0;
    longint unsigned     tbl_sum = 0;
    logic [CHANCE_W-1:0] tbl_chance = CHANCE_W'(CHANCE_RST);

    t_sel_result pending_results [$];
    int          mismatch_count = 0;

    bit          drv_typed;
    t_sel_result drv_res;
    bit          sender_bursty = 1'b1;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    t_step_row   dir_rows [$];

    function automatic t_sel_result predict_selection(input logic op,
            input logic [15:0] w, input logic [CHANCE_W-1:0] cr,
            input logic [FINE_W-1:0] fr);
        t_sel_result     r;
        logic [WGT_W-1:0] wq;
        longint unsigned roll;
        longint unsigned roll_x_sum;
        longint unsigned run_sum;
        bit              found;
        r.status = STAT_NONE;
        r.index  = '0;
        found    = 1'b0;
        run_sum  = 0;
        if (op == OP_ADD) begin
            if (tbl_count >= MAX_ENTRIES) begin
                r.status = STAT_FULL;
            end else begin
                // zero or negative weight is stored as 1.0
                wq = (w == 16'd0 || w[15]) ? WGT_W'(ONE_Q8_8) : w[WGT_W-1:0];
                tbl_weight[tbl_count] = wq;
                tbl_sum += wq;
                r.status = STAT_ADDED;
                r.index  = 4'(tbl_count);
                tbl_count++;
            end
        end else if (tbl_count != 0 && cr < tbl_chance) begin
            r.status   = STAT_PICKED;
            // fall back to the last entry when nothing qualifies
            r.index    = 4'(tbl_count - 1);
            roll       = fr;
            roll_x_sum = roll * tbl_sum;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (!found && i < tbl_count) begin
                    run_sum += tbl_weight[i];
                    if (roll_x_sum <= run_sum * ROLL_SCALE) begin
                        r.index = 4'(i);
                        found   = 1'b1;
                    end
                end
            end
        end
        r.total = 5'(tbl_count);
        return r;
    endfunction

    function automatic t_step_row mk_row(input logic op, input logic [15:0] w,
            input logic [CHANCE_W-1:0] cr, input logic [FINE_W-1:0] fr,
            input bit typed, input t_status st, input int idx, input int tot);
        t_step_row row;
        row.op          = op;
        row.weight      = w;
        row.chance_roll = cr;
        row.fine_roll   = fr;
        row.typed       = typed;
        row.res.status  = st;
        row.res.index   = 4'(idx);
        row.res.total   = 5'(tot);
        return row;
    endfunction

    // Offer one item, starting and ending at a falling edge
    task automatic offer_item(input logic op, input logic [15:0] w,
            input logic [CHANCE_W-1:0] cr, input logic [FINE_W-1:0] fr,
            input bit typed, input t_sel_result res);
        int gap;
        gap = 0;
        if (sender_bursty) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv_typed = typed;
        drv_res   = res;
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_weight      <= w;
        i_chance_roll <= cr;
        i_fine_roll   <= fr;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Drop valid, drain all results, then let the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (24) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (drv_typed) begin
                void'(predict_selection(i_opcode, i_weight, i_chance_roll, i_fine_roll));
                pending_results.push_back(drv_res);
            end else begin
                pending_results.push_back(
                    predict_selection(i_opcode, i_weight, i_chance_roll, i_fine_roll));
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sel_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected item status %0d index %0d total %0d",
                         $time, o_status, o_entry_index, o_entry_total);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_entry_index !== want.index ||
                    o_entry_total !== want.total) begin
                    mismatch_count++;
                    if (o_status !== want.status)
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, o_status);
                    if (o_entry_index !== want.index)
                        $display("%0t: entry_index expected %0d got %0d",
                                 $time, want.index, o_entry_index);
                    if (o_entry_total !== want.total)
                        $display("%0t: entry_total expected %0d got %0d",
                                 $time, want.total, o_entry_total);
                end
            end
        end
    end

    // Receiver: stall pattern is picked at random from four modes; one long hold on request
    initial begin
        int stall_cycle;
        int stall_mode;
        stall_cycle = 0;
        stall_mode  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                if (stall_cycle % 128 == 0) stall_mode = $urandom_range(0, 3);
                stall_cycle++;
                case (stall_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= (stall_cycle % 7 < 4);
                endcase
            end
        end
    end

    initial begin
        logic [CHANCE_W-1:0] chance_plan [7];
        logic                op;
        logic [15:0]         w;
        logic [CHANCE_W-1:0] cr;
        logic [FINE_W-1:0]   fr;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_opcode      = OP_ADD;
        i_weight      = '0;
        i_chance_roll = '0;
        i_fine_roll   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        drv_typed     = 1'b0;
        drv_res       = '0;

        // empty table, weight extremes, gate and fallback cases, then fill up
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd0,   14'd0,     1, STAT_NONE,   0,  0));
        dir_rows.push_back(mk_row(OP_ADD,  16'h0000, 7'd0,   14'd0,     1, STAT_ADDED,  0,  1));
        dir_rows.push_back(mk_row(OP_ADD,  16'h8000, 7'd127, 14'h3fff,  1, STAT_ADDED,  1,  2));
        dir_rows.push_back(mk_row(OP_PICK, 16'h7fff, 7'd99,  14'd0,     1, STAT_PICKED, 0,  2));
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd0,   14'h3fff,  1, STAT_PICKED, 1,  2));
        dir_rows.push_back(mk_row(OP_ADD,  16'h7fff, 7'd0,   14'd0,     1, STAT_ADDED,  2,  3));
        dir_rows.push_back(mk_row(OP_ADD,  16'h0001, 7'd0,   14'd0,     1, STAT_ADDED,  3,  4));
        dir_rows.push_back(mk_row(OP_ADD,  16'hffff, 7'd0,   14'd0,     1, STAT_ADDED,  4,  5));
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd50,  14'd10000, 0, STAT_NONE,   0,  0));
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd98,  14'd9999,  0, STAT_NONE,   0,  0));
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd127, 14'd5000,  1, STAT_NONE,   0,  5));
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd100, 14'd0,     1, STAT_NONE,   0,  5));
        dir_rows.push_back(mk_row(OP_ADD,  16'h0100, 7'd0,   14'd0,     1, STAT_ADDED,  5,  6));
        dir_rows.push_back(mk_row(OP_ADD,  16'h4000, 7'd0,   14'd0,     1, STAT_ADDED,  6,  7));
        dir_rows.push_back(mk_row(OP_ADD,  16'h00ff, 7'd0,   14'd0,     1, STAT_ADDED,  7,  8));
        dir_rows.push_back(mk_row(OP_ADD,  16'h8001, 7'd0,   14'd0,     1, STAT_ADDED,  8,  9));
        dir_rows.push_back(mk_row(OP_ADD,  16'h2a3c, 7'd0,   14'd0,     1, STAT_ADDED,  9, 10));
        dir_rows.push_back(mk_row(OP_ADD,  16'h0800, 7'd0,   14'd0,     1, STAT_ADDED, 10, 11));
        dir_rows.push_back(mk_row(OP_ADD,  16'h1234, 7'd0,   14'd0,     1, STAT_ADDED, 11, 12));
        dir_rows.push_back(mk_row(OP_ADD,  16'h7ffe, 7'd0,   14'd0,     1, STAT_ADDED, 12, 13));
        dir_rows.push_back(mk_row(OP_ADD,  16'h0040, 7'd0,   14'd0,     1, STAT_ADDED, 13, 14));
        dir_rows.push_back(mk_row(OP_ADD,  16'h5555, 7'd0,   14'd0,     1, STAT_ADDED, 14, 15));
        dir_rows.push_back(mk_row(OP_ADD,  16'h0003, 7'd0,   14'd0,     1, STAT_ADDED, 15, 16));
        dir_rows.push_back(mk_row(OP_ADD,  16'h1234, 7'd0,   14'd0,     1, STAT_FULL,   0, 16));
        dir_rows.push_back(mk_row(OP_PICK, 16'h0000, 7'd42,  14'd9999,  0, STAT_NONE,   0,  0));

        chance_plan[0] = 7'd127;
        chance_plan[1] = 7'd0;
        chance_plan[2] = 7'd1;
        chance_plan[3] = 7'd100;
        chance_plan[4] = 7'd99;
        chance_plan[5] = 7'd50;
        chance_plan[6] = 7'($urandom_range(0, 127));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            offer_item(dir_rows[k].op, dir_rows[k].weight, dir_rows[k].chance_roll,
                       dir_rows[k].fine_roll, dir_rows[k].typed, dir_rows[k].res);

        for (int ph = 0; ph < 7; ph++) begin
            drain_results();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= chance_plan[ph];
            @(negedge i_clk);
            i_cfg_we    <= 1'b0;
            tbl_chance   = chance_plan[ph];
            // back-to-back items against a long output stall fill the block
            sender_bursty = (ph != 3);
            hold_req      = (ph == 3);
            repeat (272) begin
                op = ($urandom_range(0, 99) < 15) ? OP_ADD : OP_PICK;
                case ($urandom_range(0, 7))
                    0: w = 16'h0000;
                    1: w = 16'h8000;
                    2: w = 16'h7fff;
                    default: w = 16'($urandom);
                endcase
                cr = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, 99));
                case ($urandom_range(0, 9))
                    0: fr = 14'($urandom);
                    1: fr = 14'($urandom_range(9990, 10010));
                    default: fr = 14'($urandom_range(0, 9999));
                endcase
                offer_item(op, w, cr, fr, 1'b0, '0);
            end
        end
        drain_results();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> weighted_random_selector.f
+incdir+hw/rtl
hw/rtl/wrs_pkg.sv
hw/rtl/wrs_store.sv
hw/rtl/wrs_scan.sv
hw/rtl/weighted_random_selector.sv
dv/tb_weighted_random_selector.sv
